### sv/cbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_pkg
// Types, constants and helpers shared by the channel blacklist table modules.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int TIME_W        = 48;
	localparam int NODE_W        = 16;
	localparam int CHAN_W        = 5;
	localparam int PERIOD_W      = 16;
	localparam int FUNC_W        = 3;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam int CH_MIN     = 11;
	localparam int CH_MAX     = 26;
	localparam int SEARCH_CAP = 16;

	localparam logic [FUNC_W-1:0] FUNC_ADD_PRIV = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD_NBR  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FIND_ALT = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_EXPIRE   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [NODE_W-1:0]   node_id;
		logic [CHAN_W-1:0]   channel;
		logic [PERIOD_W-1:0] period;
		logic [TIME_W-1:0]   start_time;
		logic [TIME_W-1:0]   end_time;
		logic [TIME_W-1:0]   now_time;
	} cbt_in_t;

	typedef struct packed {
		logic              blacklisted;
		logic              alt_found;
		logic [CHAN_W-1:0] alt_channel;
		logic              status;
	} cbt_out_t;

	typedef struct packed {
		logic                valid;
		logic                priv;
		logic [NODE_W-1:0]   node;
		logic [CHAN_W-1:0]   channel;
		logic [PERIOD_W-1:0] period;
		logic [TIME_W-1:0]   start_time;
		logic [TIME_W-1:0]   end_time;
	} entry_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic step;
	} cbt_cmd_t;

	typedef struct packed {
		logic search_end;
	} cbt_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH
	} cbt_state_t;

	// One hop of the alternate search, wrapping past the top channel.
	function automatic logic [CHAN_W-1:0] step_channel(input logic [CHAN_W-1:0] cand,
			input logic [CHAN_W-1:0] off);
		logic [CHAN_W:0] sum;
		sum = {1'b0, cand} + {1'b0, off};
		if (sum > (CHAN_W+1)'(CH_MAX)) begin
			sum = sum - (CHAN_W+1)'(CH_MAX + 1 - CH_MIN);
		end
		return sum[CHAN_W-1:0];
	endfunction

endpackage

### sv/cbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_ctrl
// Sequencer that accepts a command and steps the table datapath through it.
// ----------------------------------------------------------------------------
module cbt_ctrl import cbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  cbt_sts_t          sts,
	output cbt_cmd_t          cmd,
	output logic              busy
);

	cbt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (func == FUNC_FIND_ALT) ? ST_SEARCH : ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			ST_SEARCH: begin
				if (sts.search_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.exec = (state_q == ST_EXEC);
		cmd.step = (state_q == ST_SEARCH);
		busy     = (state_q != ST_IDLE);
	end

endmodule

### sv/cbt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_datapath
// Entry table, configuration registers, parallel matchers and result register.
// ----------------------------------------------------------------------------
module cbt_datapath import cbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbt_cmd_t              cmd,
	input  cbt_in_t               item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cbt_sts_t              sts,
	output logic                  done,
	output cbt_out_t              result
);

	localparam int N = TABLE_ENTRIES;

	entry_t            table_q [N];
	cbt_in_t           item_q;
	logic [NODE_W-1:0] own_node_q;
	logic [CHAN_W-1:0] swap_q;
	logic [CHAN_W-1:0] count_q;
	logic [CHAN_W-1:0] cand_q;
	logic [CHAN_W-1:0] k_q;
	cbt_out_t          res_q;
	logic              done_q;

	logic [CHAN_W-1:0] off_eff, cnt_eff, cand_nxt;
	logic              search_empty, search_last;
	logic              listed_now, listed_cand;
	logic              is_priv_add, is_add;
	logic [N-1:0]      add_m, add_first, free_m, free_first, exp_m, exp_first, exp_ge;
	logic              exp_priv;
	cbt_out_t          exec_res, search_res;

	assign off_eff  = (swap_q > CHAN_W'(SEARCH_CAP)) ? CHAN_W'(SEARCH_CAP) : swap_q;
	assign cnt_eff  = (count_q > CHAN_W'(SEARCH_CAP)) ? CHAN_W'(SEARCH_CAP) : count_q;
	assign cand_nxt = step_channel(cand_q, off_eff);
	assign search_empty = (off_eff == '0) || (cnt_eff == '0);
	assign search_last  = (k_q + CHAN_W'(1)) >= cnt_eff;

	assign is_priv_add = (item_q.func == FUNC_ADD_PRIV);
	assign is_add      = is_priv_add || (item_q.func == FUNC_ADD_NBR);
	assign exp_priv    = (item_q.node_id == own_node_q);

	// Every entry is compared at once; the table stays packed at the low slots.
	always_comb begin
		listed_now  = 1'b0;
		listed_cand = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (table_q[i].valid && (table_q[i].priv || table_q[i].node == item_q.node_id)
					&& table_q[i].start_time < item_q.now_time
					&& item_q.now_time < table_q[i].end_time) begin
				if (table_q[i].channel == item_q.channel) begin
					listed_now = 1'b1;
				end
				if (table_q[i].channel == cand_nxt) begin
					listed_cand = 1'b1;
				end
			end
			add_m[i] = table_q[i].valid
				&& (is_priv_add ? table_q[i].priv
					: (!table_q[i].priv && table_q[i].node == item_q.node_id))
				&& table_q[i].channel == item_q.channel
				&& table_q[i].period == item_q.period;
			exp_m[i] = table_q[i].valid
				&& (exp_priv ? table_q[i].priv
					: (!table_q[i].priv && table_q[i].node == item_q.node_id))
				&& table_q[i].channel == item_q.channel
				&& table_q[i].end_time <= item_q.now_time;
			free_m[i] = !table_q[i].valid;
		end
		add_first  = add_m & (~add_m + N'(1));
		free_first = free_m & (~free_m + N'(1));
		exp_first  = exp_m & (~exp_m + N'(1));
		exp_ge     = ~(exp_first - N'(1));
	end

	always_comb begin
		exec_res             = '0;
		exec_res.blacklisted = (item_q.func == FUNC_QUERY) && listed_now;
		exec_res.status      = is_add && (add_m == '0) && (free_m == '0);
		search_res           = '0;
		search_res.alt_found = !search_empty && !listed_cand;
		search_res.alt_channel = search_res.alt_found ? cand_nxt : '0;
	end

	assign sts.search_end = search_empty || !listed_cand || search_last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			res_q <= exec_res;
		end else if (cmd.step && sts.search_end) begin
			res_q <= search_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q <= '0;
			swap_q     <= '0;
			count_q    <= CHAN_W'(SEARCH_CAP);
			cand_q     <= '0;
			k_q        <= '0;
			done_q     <= 1'b0;
			for (int i = 0; i < N; i++) begin
				table_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.exec || (cmd.step && sts.search_end);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OWN_NODE:    own_node_q <= cfg_wdata[NODE_W-1:0];
					CFG_SWAP_OFFSET: swap_q     <= cfg_wdata[CHAN_W-1:0];
					CFG_CHAN_COUNT:  count_q    <= cfg_wdata[CHAN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				cand_q <= item.channel;
				k_q    <= '0;
			end
			if (cmd.step && !sts.search_end) begin
				cand_q <= cand_nxt;
				k_q    <= k_q + CHAN_W'(1);
			end
			if (cmd.exec && is_add) begin
				for (int i = 0; i < N; i++) begin
					if (add_m != '0) begin
						if (add_first[i]) begin
							if (item_q.start_time < table_q[i].start_time) begin
								table_q[i].start_time <= item_q.start_time;
							end
							if (item_q.end_time > table_q[i].end_time) begin
								table_q[i].end_time <= item_q.end_time;
							end
						end
					end else if (free_first[i]) begin
						table_q[i].valid      <= 1'b1;
						table_q[i].priv       <= is_priv_add;
						table_q[i].node       <= is_priv_add ? own_node_q : item_q.node_id;
						table_q[i].channel    <= item_q.channel;
						table_q[i].period     <= item_q.period;
						table_q[i].start_time <= item_q.start_time;
						table_q[i].end_time   <= item_q.end_time;
					end
				end
			end
			// Removing an entry slides every later entry down one slot.
			if (cmd.exec && item_q.func == FUNC_EXPIRE && exp_m != '0) begin
				for (int j = 0; j < N - 1; j++) begin
					if (exp_ge[j]) begin
						table_q[j] <= table_q[j+1];
					end
				end
				table_q[N-1] <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### sv/channel_blacklist_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_blacklist_table
// Radio channel blacklist table with insert, query, alternate search, expiry.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low; its fields
// arrive packed in item. Every transaction gives exactly one result, shown on
// result for one cycle while done is high; the receiver cannot stall it.
// Insert, query, expiry and unused codes pass through the execute state, at
// whose end done and the result register are loaded. The alternate search
// tests one candidate channel per cycle against all entries in parallel. It
// stops at the first free channel or when the channel count is used up, and
// a disabled search (zero offset or zero count) ends on its first step; done
// is registered from the last step. The next command can be taken in the
// cycle that done is high.
// Configuration goes through cfg_we, cfg_index and cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset empties the table and loads the register defaults at once; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module channel_blacklist_table import cbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cbt_in_t               item,
	output logic                  done,
	output cbt_out_t              result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cbt_cmd_t cmd;
	cbt_sts_t sts;

	cbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cbt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule
